// ----- sv/bba_pkg.sv -----
package bba_pkg;

    localparam int MAX_BLOCKS = 65536;
    localparam int MAX_GROUPS = 16;
    localparam int WORD_BITS  = 64;

    localparam int CNT_W     = 17;
    localparam int BLKNUM_W  = 16;
    localparam int BLK_W     = $clog2(MAX_BLOCKS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_WORDS = MAX_BLOCKS / WORD_BITS;
    localparam int AW        = $clog2(MAP_WORDS);
    localparam int GRP_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int ACC_W     = CNT_W + GRP_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_DATA_BLOCK = 2'd0,
        CFG_BLOCKS_PER_GROUP = 2'd1,
        CFG_TOTAL_BLOCKS     = 2'd2,
        CFG_GROUP_COUNT      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                 en;
        logic [AW-1:0]        addr;
        logic [WORD_BITS-1:0] data;
    } map_wr_t;

    typedef struct packed {
        logic             hit;
        logic [GRP_W-1:0] tgt;
        logic [CNT_W-1:0] cap;
    } geo_res_t;

endpackage

// ----- sv/bba_map.sv -----
module bba_map (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bba_pkg::map_wr_t              wr,
    input  logic [bba_pkg::AW-1:0]        rd_addr,
    output logic [bba_pkg::WORD_BITS-1:0] rd_data,
    output logic                          ready
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [AW-1:0]        clr_reg;
    logic                 clr_on_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg    <= '0;
            clr_on_reg <= 1'b1;
        end else if (clr_on_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == AW'(MAP_WORDS - 1)) begin
                clr_on_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_on_reg) begin
            mem[clr_reg] <= '0;
        end else if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

    assign ready = !clr_on_reg;

endmodule

// ----- sv/bba_geom.sv -----
module bba_geom (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       fdb,
    input  logic [bba_pkg::CNT_W-1:0]  bpg,
    input  logic [bba_pkg::CNT_W-1:0]  et,
    input  logic [bba_pkg::GRP_W:0]    n,
    input  logic [bba_pkg::BLK_W-1:0]  key,
    input  logic [bba_pkg::GRP_W-1:0]  rd_idx,
    output logic                       done,
    output bba_pkg::geo_res_t          res,
    output logic [bba_pkg::CNT_W-1:0]  lim_rd,
    output logic [bba_pkg::CNT_W-1:0]  base_rd
);
    import bba_pkg::*;

    logic [CNT_W-1:0] lim_arr  [MAX_GROUPS];
    logic [CNT_W-1:0] base_arr [MAX_GROUPS];
    logic [ACC_W-1:0] acc_reg;
    logic [GRP_W:0]   g_reg;
    logic             busy_reg;
    logic             done_reg;
    geo_res_t         res_reg;

    logic [ACC_W-1:0] first_abs;
    logic [ACC_W-1:0] acc_end;
    logic [CNT_W-1:0] lim;
    logic             in_use;
    logic             last;

    always_comb begin
        first_abs = acc_reg + ACC_W'(fdb);
        acc_end   = acc_reg + ACC_W'(bpg);
        if (first_abs >= ACC_W'(et)) begin
            lim = '0;
        end else if (first_abs + ACC_W'(bpg) > ACC_W'(et)) begin
            lim = CNT_W'(ACC_W'(et) - first_abs);
        end else begin
            lim = bpg;
        end
        in_use = g_reg < n;
        last   = g_reg == (GRP_W+1)'(MAX_GROUPS - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            g_reg    <= '0;
            acc_reg  <= '0;
            res_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                g_reg    <= '0;
                acc_reg  <= '0;
                res_reg  <= '0;
            end else if (busy_reg) begin
                lim_arr[g_reg[GRP_W-1:0]]  <= lim;
                base_arr[g_reg[GRP_W-1:0]] <= acc_reg[CNT_W-1:0];
                if (in_use) begin
                    res_reg.cap <= res_reg.cap + lim;
                    if (ACC_W'(key) >= acc_reg && ACC_W'(key) < acc_end) begin
                        res_reg.hit <= 1'b1;
                        res_reg.tgt <= g_reg[GRP_W-1:0];
                    end
                end
                acc_reg <= acc_end;
                g_reg   <= g_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done    = done_reg;
    assign res     = res_reg;
    assign lim_rd  = lim_arr[rd_idx];
    assign base_rd = base_arr[rd_idx];

endmodule

// ----- sv/block_bitmap_allocator.sv -----
// Block allocator over a 65536-bit usage bitmap held in a 1024 x 64 memory. After reset the
// bitmap is cleared word by word, and s_tready stays low meanwhile. Each request then walks
// the group geometry (one group per cycle through one add/compare unit); a free then reads
// the bitmap word and clears the block's bit, and an allocation visits groups one by one and
// for each bitmap word does a memory read, then a first-clear-bit search, so its time grows
// with how full the groups ahead of the goal are. One request is in work at a time; the
// result stays in the output register until taken.
module block_bitmap_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bba_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,  // goal_block[31:0], block_to_free[63:32]
    input  logic                           s_tuser,  // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], block_number[17:2], changed[18], group_free[35:19], total_free[52:36]
    output logic [55:0]                    m_tdata
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_GEO, S_PICK, S_RD, S_CHK, S_FRD, S_FCHK, S_FIN
    } state_t;

    state_t           state_reg;
    logic             fdb_reg;
    logic [CNT_W-1:0] bpg_reg, tot_reg;
    logic [4:0]       gc_reg;
    logic [CNT_W-1:0] used_reg [MAX_GROUPS];
    logic [CNT_W-1:0] tused_reg;

    logic             kind_reg, inrng_reg, changed_reg, gfz_reg;
    logic [31:0]      abs_reg;
    logic [BLK_W-1:0] rel_reg;
    logic [GRP_W-1:0] g_reg;
    logic [GRP_W:0]   pass_reg;
    logic [AW-1:0]    word_reg;
    logic [CNT_W-1:0] end_reg;
    logic [BLKNUM_W-1:0] blk_reg;
    status_t          st_reg;
    logic             m_valid_reg;
    logic [55:0]      m_data_reg;

    logic [CNT_W-1:0] bpg_eff, et;
    logic [GRP_W:0]   n;
    logic [31:0]      in_abs;
    logic             geo_start, geo_done, map_ready;
    geo_res_t         geo;
    logic [CNT_W-1:0] lim_rd, base_rd;
    map_wr_t          wr;
    logic [AW-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data, free_bits;
    logic             any_free;
    logic [BIT_W-1:0] free_idx;
    logic [GRP_W-1:0] g_nxt;
    logic [CNT_W-1:0] used_g, gf, tf;

    assign bpg_eff = (bpg_reg == '0) ? CNT_W'(1) : bpg_reg;
    assign et      = (tot_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : tot_reg;
    assign n       = (gc_reg > 5'(MAX_GROUPS)) ? (GRP_W+1)'(MAX_GROUPS) : (GRP_W+1)'(gc_reg);
    assign in_abs  = s_tuser ? s_tdata[63:32] : s_tdata[31:0];
    assign s_tready  = (state_reg == S_IDLE) && map_ready;
    assign geo_start = s_tvalid && s_tready;
    assign g_nxt   = (pass_reg + 1'b1 >= n || (GRP_W+1)'(g_reg) == n - 1'b1) ? '0 : g_reg + 1'b1;
    assign used_g  = used_reg[g_reg];

    bba_geom u_geom (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (geo_start),
        .fdb     (fdb_reg),
        .bpg     (bpg_eff),
        .et      (et),
        .n       (n),
        .key     (rel_reg),
        .rd_idx  (g_reg),
        .done    (geo_done),
        .res     (geo),
        .lim_rd  (lim_rd),
        .base_rd (base_rd)
    );

    bba_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .ready   (map_ready)
    );

    assign rd_addr = word_reg;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            free_bits[j] = !rd_data[j]
                && CNT_W'({word_reg, BIT_W'(j)}) >= base_rd
                && CNT_W'({word_reg, BIT_W'(j)}) < end_reg;
        end
        any_free = |free_bits;
        free_idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                free_idx = BIT_W'(j);
            end
        end
    end

    always_comb begin
        wr = '0;
        if (state_reg == S_CHK && any_free) begin
            wr.en   = 1'b1;
            wr.addr = word_reg;
            wr.data = rd_data | (WORD_BITS'(1) << free_idx);
        end else if (state_reg == S_FCHK && rd_data[rel_reg[BIT_W-1:0]]) begin
            wr.en   = 1'b1;
            wr.addr = word_reg;
            wr.data = rd_data & ~(WORD_BITS'(1) << rel_reg[BIT_W-1:0]);
        end
    end

    always_comb begin
        gf = (gfz_reg || used_g >= lim_rd) ? '0 : lim_rd - used_g;
        tf = (tused_reg >= geo.cap) ? '0 : geo.cap - tused_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fdb_reg <= 1'b0;
            bpg_reg <= CNT_W'(8192);
            tot_reg <= CNT_W'(65536);
            gc_reg  <= 5'd8;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FIRST_DATA_BLOCK: fdb_reg <= cfg_wdata[0];
                CFG_BLOCKS_PER_GROUP: bpg_reg <= cfg_wdata;
                CFG_TOTAL_BLOCKS:     tot_reg <= cfg_wdata;
                CFG_GROUP_COUNT:      gc_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            tused_reg   <= '0;
            for (int i = 0; i < MAX_GROUPS; i++) begin
                used_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (geo_start) begin
                        kind_reg    <= s_tuser;
                        abs_reg     <= in_abs;
                        inrng_reg   <= in_abs >= 32'(fdb_reg) && in_abs < 32'(et);
                        rel_reg     <= BLK_W'(in_abs - 32'(fdb_reg));
                        changed_reg <= 1'b0;
                        state_reg   <= S_GEO;
                    end
                end
                S_GEO: begin
                    if (geo_done) begin
                        pass_reg <= '0;
                        word_reg <= rel_reg[BLK_W-1:BIT_W];
                        if (!kind_reg) begin
                            g_reg     <= (geo.hit && inrng_reg) ? geo.tgt : '0;
                            state_reg <= S_PICK;
                        end else if (!inrng_reg || !geo.hit) begin
                            st_reg    <= ST_INVALID;
                            blk_reg   <= abs_reg[BLKNUM_W-1:0];
                            gfz_reg   <= 1'b1;
                            state_reg <= S_FIN;
                        end else begin
                            g_reg     <= geo.tgt;
                            state_reg <= S_FRD;
                        end
                    end
                end
                S_PICK: begin
                    if (pass_reg >= n) begin
                        st_reg    <= ST_NOSPACE;
                        blk_reg   <= '0;
                        gfz_reg   <= 1'b1;
                        state_reg <= S_FIN;
                    end else if (lim_rd == '0 || used_g >= lim_rd) begin
                        g_reg    <= g_nxt;
                        pass_reg <= pass_reg + 1'b1;
                    end else begin
                        word_reg  <= base_rd[BLK_W-1:BIT_W];
                        end_reg   <= base_rd + lim_rd;
                        state_reg <= S_RD;
                    end
                end
                S_RD: state_reg <= S_CHK;
                S_CHK: begin
                    if (any_free) begin
                        if (used_g < COUNT_MAX) used_reg[g_reg] <= used_g + 1'b1;
                        if (tused_reg < COUNT_MAX) tused_reg <= tused_reg + 1'b1;
                        st_reg      <= ST_OK;
                        blk_reg     <= BLKNUM_W'(CNT_W'({word_reg, free_idx}) + CNT_W'(fdb_reg));
                        changed_reg <= 1'b1;
                        gfz_reg     <= 1'b0;
                        state_reg   <= S_FIN;
                    end else if (word_reg == AW'((end_reg - 1'b1) >> BIT_W)) begin
                        g_reg     <= g_nxt;
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= S_PICK;
                    end else begin
                        word_reg  <= word_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_FRD: state_reg <= S_FCHK;
                S_FCHK: begin
                    if (rd_data[rel_reg[BIT_W-1:0]]) begin
                        if (used_g != '0) used_reg[g_reg] <= used_g - 1'b1;
                        if (tused_reg != '0) tused_reg <= tused_reg - 1'b1;
                        changed_reg <= 1'b1;
                    end
                    st_reg    <= ST_OK;
                    blk_reg   <= abs_reg[BLKNUM_W-1:0];
                    gfz_reg   <= 1'b0;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'b000, tf, gf, changed_reg, blk_reg, st_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import bba_pkg::*;

    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [16:0] total_free;
        logic [16:0] group_free;
        logic        changed;
        logic [15:0] block_number;
        status_t     status;
    } alloc_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [55:0]          m_tdata;

    block_bitmap_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // shadow of the allocator
    longint   fdb_reg, bpg_reg, total_reg, groups_reg;
    bit       used_map [MAX_BLOCKS];
    longint   grp_used [MAX_GROUPS];
    longint   vol_used;
    int       held_blocks [$];

    alloc_result_t pending_results [$];
    int       errors;
    longint   cycles;
    bit       no_idle;
    int       stall_left;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("block_bitmap_allocator: mismatch");
            $finish;
        end
    end

    function automatic longint eff_bpg();
        return (bpg_reg == 0) ? 1 : bpg_reg;
    endfunction

    function automatic longint eff_total();
        return (total_reg > MAX_BLOCKS) ? MAX_BLOCKS : total_reg;
    endfunction

    function automatic longint eff_groups();
        return (groups_reg > MAX_GROUPS) ? MAX_GROUPS : groups_reg;
    endfunction

    function automatic longint group_size(longint g);
        longint first;
        first = fdb_reg + g * eff_bpg();
        if (first >= eff_total())
            return 0;
        if (first + eff_bpg() > eff_total())
            return eff_total() - first;
        return eff_bpg();
    endfunction

    function automatic longint group_free_blocks(longint g);
        longint lim;
        lim = group_size(g);
        return (grp_used[g] >= lim) ? 0 : lim - grp_used[g];
    endfunction

    function automatic longint volume_free_blocks();
        longint cap;
        cap = 0;
        for (longint g = 0; g < eff_groups(); g++)
            cap += group_size(g);
        return (vol_used >= cap) ? 0 : cap - vol_used;
    endfunction

    function automatic alloc_result_t make_result(status_t st, longint blk, bit ch,
                                                  longint gf);
        alloc_result_t r;
        longint tf;
        tf = volume_free_blocks();
        r.status       = st;
        r.block_number = blk[15:0];
        r.changed      = ch;
        r.group_free   = gf[16:0];
        r.total_free   = tf[16:0];
        return r;
    endfunction

    function automatic alloc_result_t allocate_block(longint goal);
        longint n, start, g, base, lim;
        n = eff_groups();
        start = 0;
        if (goal >= fdb_reg && goal < eff_total()) begin
            start = (goal - fdb_reg) / eff_bpg();
            if (start >= n)
                start = 0;
        end
        for (longint p = 0; p < n; p++) begin
            g = (start + p) % n;
            lim = group_size(g);
            base = g * eff_bpg();
            if (lim == 0 || group_free_blocks(g) == 0)
                continue;
            for (longint i = 0; i < lim; i++) begin
                if (base + i >= MAX_BLOCKS || used_map[base + i])
                    continue;
                used_map[base + i] = 1'b1;
                if (grp_used[g] < COUNT_MAX)
                    grp_used[g]++;
                if (vol_used < COUNT_MAX)
                    vol_used++;
                held_blocks.push_back(int'(fdb_reg + base + i));
                return make_result(ST_OK, fdb_reg + base + i, 1'b1, group_free_blocks(g));
            end
        end
        return make_result(ST_NOSPACE, 0, 1'b0, 0);
    endfunction

    function automatic alloc_result_t release_block(longint blk);
        longint r, g;
        if (blk < fdb_reg || blk >= eff_total())
            return make_result(ST_INVALID, blk, 1'b0, 0);
        r = blk - fdb_reg;
        g = r / eff_bpg();
        if (g >= eff_groups())
            return make_result(ST_INVALID, blk, 1'b0, 0);
        if (!used_map[r])
            return make_result(ST_OK, blk, 1'b0, group_free_blocks(g));
        used_map[r] = 1'b0;
        if (grp_used[g] > 0)
            grp_used[g]--;
        if (vol_used > 0)
            vol_used--;
        return make_result(ST_OK, blk, 1'b1, group_free_blocks(g));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 8)
                stall_left <= $urandom_range(10, 100);
            m_tready <= (r >= 30);
        end
    end

    always @(posedge aclk) begin
        alloc_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[52:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                if (got.block_number !== want.block_number)
                    $display("%0t: block_number expected %0d actual %0d",
                             $time, want.block_number, got.block_number);
                if (got.changed !== want.changed)
                    $display("%0t: changed expected %0d actual %0d",
                             $time, want.changed, got.changed);
                if (got.group_free !== want.group_free)
                    $display("%0t: group_free expected %0d actual %0d",
                             $time, want.group_free, got.group_free);
                if (got.total_free !== want.total_free)
                    $display("%0t: total_free expected %0d actual %0d",
                             $time, want.total_free, got.total_free);
                if (got !== want)
                    errors++;
            end
        end
    end

    task automatic send_request(bit kind, logic [31:0] goal, logic [31:0] blk);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {blk, goal};
        do @(posedge aclk); while (!s_tready);
        if (kind)
            pending_results.push_back(release_block(longint'(blk)));
        else
            pending_results.push_back(allocate_block(longint'(goal)));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, longint value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CNT_W-1:0];
        case (idx)
            CFG_FIRST_DATA_BLOCK: fdb_reg = value & 1;
            CFG_BLOCKS_PER_GROUP: bpg_reg = value & COUNT_MAX;
            CFG_TOTAL_BLOCKS:     total_reg = value & COUNT_MAX;
            default:              groups_reg = value & 'h1F;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_geometry(longint fdb, longint bpg, longint total, longint groups);
        wait_idle();
        write_reg(CFG_FIRST_DATA_BLOCK, fdb);
        write_reg(CFG_BLOCKS_PER_GROUP, bpg);
        write_reg(CFG_TOTAL_BLOCKS, total);
        write_reg(CFG_GROUP_COUNT, groups);
        held_blocks.delete();
    endtask

    // mostly allocations near the volume and frees of held blocks, some noise
    task automatic random_traffic(int count);
        int mode, idx;
        logic [31:0] blk;
        for (int k = 0; k < count; k++) begin
            if (k % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 9);
            if (mode < 5) begin
                send_request(1'b0, $urandom_range(0, int'(eff_total()) + 4), $urandom);
            end else if (mode == 5) begin
                send_request(1'b0, $urandom, $urandom);
            end else if (mode < 9) begin
                if (held_blocks.size() > 0) begin
                    idx = $urandom_range(0, held_blocks.size() - 1);
                    blk = held_blocks[idx];
                    held_blocks.delete(idx);
                end else begin
                    blk = $urandom_range(0, int'(eff_total()) + 2);
                end
                send_request(1'b1, $urandom, blk);
            end else begin
                send_request(1'b1, $urandom, $urandom);
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_directed();
        send_request(1'b0, 32'd0, 32'hFFFF_FFFF);
        send_request(1'b0, 32'hFFFF_FFFF, 32'd0);
        send_request(1'b0, 32'd65535, 32'd0);
        send_request(1'b0, 32'd57344, 32'd0);
        send_request(1'b0, 32'd65536, 32'd0);
        send_request(1'b1, 32'd0, 32'd0);
        send_request(1'b1, 32'd0, 32'd0);
        send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(1'b1, 32'd0, 32'd65536);
        send_request(1'b1, 32'd0, 32'd57344);
        send_request(1'b1, 32'd0, 32'd65535);
        send_request(1'b1, 32'hAAAA_5555, 32'h5555_AAAA);
        send_request(1'b0, 32'h5555_AAAA, 32'hAAAA_5555);
    endtask

    task automatic test_default_geometry();
        random_traffic(500);
    endtask

    task automatic test_full_groups();
        set_geometry(1, 3, 50, 16);
        send_request(1'b1, 32'd0, 32'd0);
        random_traffic(450);
        set_geometry(0, 100, 700, 5);
        random_traffic(400);
    endtask

    task automatic test_extreme_geometry();
        set_geometry(1, 0, 40, 31);
        random_traffic(120);
        set_geometry(0, 65536, 131071, 1);
        random_traffic(150);
        set_geometry(1, 65536, 65536, 16);
        random_traffic(60);
        set_geometry(0, 1, 0, 16);
        random_traffic(40);
        set_geometry(0, 7, 90, 0);
        random_traffic(40);
        set_geometry(0, 4096, 65536, 16);
        random_traffic(100);
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        errors    = 0;
        cycles    = 0;
        no_idle   = 1'b0;
        fdb_reg   = 0;
        bpg_reg   = 8192;
        total_reg = 65536;
        groups_reg = 8;
        vol_used  = 0;
        foreach (used_map[i]) used_map[i] = 1'b0;
        foreach (grp_used[i]) grp_used[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_default_geometry();
        test_full_groups();
        test_extreme_geometry();

        wait_idle();
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("block_bitmap_allocator: match");
        else
            $display("block_bitmap_allocator: mismatch");
        $finish;
    end

endmodule
